// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Request and status codes, default sizes and the control word that the
// top level broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Default sizes, handed down through the top-level parameters.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the result fields.
    localparam int OUT_W = 32;
    localparam int OCC_W = 5;

    // Request codes as they arrive on req_type.
    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_t;

    // Status codes reported with every result.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SETTLE = 1'b1
    } state_t;

    // Control word broadcast to every cell.
    typedef struct packed {
        logic en;
        req_t req;
    } cell_ctl_t;

endpackage

// ===== src/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell: one storage slot of the double-ended queue
// Holds one word and a valid bit. Pushes and pops at the front shift the
// whole row by one slot; pushes and pops at the rear touch only the slot at
// the boundary between valid and empty cells.
// ----------------------------------------------------------------------------
module dq_cell
    import dq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic                  left_valid,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  right_valid,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  valid,
    output logic                  tail
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  valid_reg;
    logic                  valid_next;

    // This cell holds the rear entry when its right neighbor is empty.
    assign tail  = valid_reg && !right_valid;
    assign data  = data_reg;
    assign valid = valid_reg;

    // Next contents of the slot for the broadcast request.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctl.en)
        begin
            case (ctl.req)
                REQ_PUSH_FRONT:
                begin
                    data_next  = left_data;
                    valid_next = left_valid;
                end
                REQ_POP_FRONT:
                begin
                    data_next  = right_data;
                    valid_next = right_valid;
                end
                REQ_PUSH_REAR:
                begin
                    if (!valid_reg && left_valid)
                    begin
                        data_next  = push_data;
                        valid_next = 1'b1;
                    end
                end
                REQ_POP_REAR:
                begin
                    if (tail)
                    begin
                        valid_next = 1'b0;
                    end
                end
                default:
                begin
                    data_next  = data_reg;
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // The valid bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The stored word needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed words
// A row of DEPTH cells keeps the entries in order, the front entry in the
// first cell. Each request pushes or pops at either end and yields one result
// with the popped word, a status, the occupancy and the front and rear words.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_ready  req_type, push_value
//   output    out_valid / out_ready popped_value, status, occupancy,
//                                  front_value, rear_value, is_empty
//
// A request first shifts or loads the cells on the transfer edge, and then the
// settle state reads the new front and rear words into the output register.
// A new request is taken while the previous result still waits.
// If the output register is still full, the settle state waits for it.
// Reset empties the queue at once; the stored words are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic signed [OUT_W-1:0] push_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] popped_value,
    output logic [1:0]              status,
    output logic [OCC_W-1:0]        occupancy,
    output logic signed [OUT_W-1:0] front_value,
    output logic signed [OUT_W-1:0] rear_value,
    output logic                    is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W;

    // Cell row.
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] push_word;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_valid;
    logic [DEPTH-1:0]      cell_tail;
    logic [DATA_WIDTH-1:0] tail_data;

    // Control and result registers.
    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [DATA_WIDTH-1:0]   pop_pend_reg;
    logic [DATA_WIDTH-1:0]   pop_pend_next;
    logic                    pop_ok_reg;
    logic                    pop_ok_next;
    status_t                 stat_pend_reg;
    status_t                 stat_pend_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_load;
    logic signed [OUT_W-1:0] popped_value_reg;
    logic [1:0]              status_reg;
    logic [OCC_W-1:0]        occupancy_reg;
    logic signed [OUT_W-1:0] front_value_reg;
    logic signed [OUT_W-1:0] rear_value_reg;
    logic                    is_empty_reg;

    // Sign extension of stored words and widening of the count.
    logic [EXT_W-1:0]         push_ext;
    logic signed [EXT_W-1:0]  front_ext;
    logic signed [EXT_W-1:0]  rear_ext;
    logic signed [EXT_W-1:0]  pop_ext;
    logic [CNT_W+OCC_W-1:0]   occ_ext;
    logic                     in_xfer;
    logic                     is_full;
    logic                     empty_now;
    req_t                     req;

    assign req       = req_t'(req_type);
    assign push_ext  = EXT_W'($unsigned(push_value));
    assign push_word = push_ext[DATA_WIDTH-1:0];
    assign is_full   = cell_valid[DEPTH-1];
    assign empty_now = !cell_valid[0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;

    // Row of storage cells; the ends see a fixed neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] l_data;
        logic                  l_valid;
        logic [DATA_WIDTH-1:0] r_data;
        logic                  r_valid;

        if (i == 0)
        begin : g_first
            assign l_data  = push_word;
            assign l_valid = 1'b1;
        end
        else
        begin : g_inner_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_inner_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .push_data   (push_word),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tail        (cell_tail[i])
        );
    end

    // Rear word: at most one cell flags itself as the tail.
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_data = tail_data | (cell_data[i] & {DATA_WIDTH{cell_tail[i]}});
        end
    end

    assign front_ext = EXT_W'($signed(cell_data[0]));
    assign rear_ext  = EXT_W'($signed(tail_data));
    assign pop_ext   = EXT_W'($signed(pop_pend_reg));
    assign occ_ext   = (CNT_W + OCC_W)'(count_reg);

    // Request decode on the input transfer, then result capture.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pop_pend_next  = pop_pend_reg;
        pop_ok_next    = pop_ok_reg;
        stat_pend_next = stat_pend_reg;
        ctl.en         = 1'b0;
        ctl.req        = req;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next     = ST_SETTLE;
                    stat_pend_next = STAT_OK;
                    pop_ok_next    = 1'b0;
                    pop_pend_next  = cell_data[0];
                    case (req)
                        REQ_PUSH_FRONT, REQ_PUSH_REAR:
                        begin
                            if (is_full)
                            begin
                                stat_pend_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ctl.en     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_REAR:
                        begin
                            if (empty_now)
                            begin
                                stat_pend_next = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ctl.en      = 1'b1;
                                pop_ok_next = 1'b1;
                                count_next  = count_reg - 1'b1;
                                if (req == REQ_POP_REAR)
                                begin
                                    pop_pend_next = tail_data;
                                end
                            end
                        end
                        default:
                        begin
                            ctl.en = 1'b0;
                        end
                    endcase
                end
            end
            ST_SETTLE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pending result of the request in flight and the output register.
    always_ff @(posedge clk)
    begin
        pop_pend_reg  <= pop_pend_next;
        pop_ok_reg    <= pop_ok_next;
        stat_pend_reg <= stat_pend_next;
        if (out_load)
        begin
            popped_value_reg <= pop_ok_reg ? pop_ext[OUT_W-1:0] : '0;
            status_reg       <= stat_pend_reg;
            occupancy_reg    <= occ_ext[OCC_W-1:0];
            front_value_reg  <= empty_now ? '0 : front_ext[OUT_W-1:0];
            rear_value_reg   <= empty_now ? '0 : rear_ext[OUT_W-1:0];
            is_empty_reg     <= empty_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;
    assign front_value  = front_value_reg;
    assign rear_value   = rear_value_reg;
    assign is_empty     = is_empty_reg;

endmodule

// ===== src/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the result channel of the top level and checks that the reported
// fields agree with one another and that a stalled result holds.
// ----------------------------------------------------------------------------
module dq_checker
    import dq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] popped_value,
    input logic [1:0]              status,
    input logic [OCC_W-1:0]        occupancy,
    input logic signed [OUT_W-1:0] front_value,
    input logic signed [OUT_W-1:0] rear_value,
    input logic                    is_empty
);

    // An empty queue reports zero occupancy and zero end words.
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |->
            (occupancy == '0 && front_value == '0 && rear_value == '0))
        else $error("empty result carries nonzero fields");

    // A refused request never reports a popped word.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_OVERFLOW || status == STAT_UNDERFLOW)) |->
            (popped_value == '0))
        else $error("refused request reports a popped word");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (status == STAT_OK || status == STAT_OVERFLOW || status == STAT_UNDERFLOW))
        else $error("undefined status code");

    // Underflow is only reported when the queue is empty.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_UNDERFLOW) |-> is_empty)
        else $error("underflow reported on a non-empty queue");

    // A stalled result stays valid and unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(popped_value) && $stable(status)
             && $stable(front_value) && $stable(rear_value)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy),
    .front_value  (front_value),
    .rear_value   (rear_value),
    .is_empty     (is_empty)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the double-ended queue
// A queue of pending requests feeds a clocked driver. A clocked monitor keeps
// its own copy of the deque's circular buffer, predicts one result for every
// request transfer, and checks each result transfer field by field against
// the oldest prediction. A directed opening covers both empty-pop refusals,
// the extreme words and the full queue with both overflow refusals. Random
// runs then swing the occupancy between empty and full under three idling
// patterns, with one long receiver hold-off and a pause between phases.
// ----------------------------------------------------------------------------
module testbench;
    import dq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTED    = 40;

    // One request as the driver offers it.
    typedef struct packed {
        req_t                    kind;
        logic signed [OUT_W-1:0] word;
    } request_t;

    // One result as the block reports it.
    typedef struct packed {
        logic signed [OUT_W-1:0] popped;
        status_t                 status;
        logic [OCC_W-1:0]        occupancy;
        logic signed [OUT_W-1:0] front;
        logic signed [OUT_W-1:0] rear;
        logic                    empty;
    } outcome_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic [1:0]              req_type   = REQ_PUSH_FRONT;
    logic signed [OUT_W-1:0] push_value = '0;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic signed [OUT_W-1:0] popped_value;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
    logic signed [OUT_W-1:0] front_value;
    logic signed [OUT_W-1:0] rear_value;
    logic                    is_empty;

    // Stimulus and expectation stores.
    request_t request_queue[$];
    outcome_t awaited_results[$];

    // Shadow copy of the deque contents.
    logic signed [OUT_W-1:0] dq_slots [DEPTH];
    logic [IDX_W-1:0]        dq_head  = '0;
    logic [IDX_W-1:0]        dq_tail  = '0;
    logic [OCC_W-1:0]        dq_count = '0;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold     = 1'b0;
    logic hold_go     = 1'b0;
    logic in_taken    = 1'b0;
    int   mismatches  = 0;
    int   cycle_count = 0;

    double_ended_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .status       (status),
        .occupancy    (occupancy),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty)
    );

    // Free-running clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic note_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
    endtask

    // Apply one request to the shadow deque and work out its result.
    task automatic apply_request(input req_t kind, input logic signed [OUT_W-1:0] word,
                                 output outcome_t res);
        res        = '0;
        res.status = STAT_OK;
        case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (dq_count == DEPTH)
                    res.status = STAT_OVERFLOW;
                else if (kind == REQ_PUSH_FRONT)
                begin
                    dq_head           = dq_head - 1'b1;
                    dq_slots[dq_head] = word;
                    dq_count          = dq_count + 1'b1;
                end
                else
                begin
                    dq_slots[dq_tail] = word;
                    dq_tail           = dq_tail + 1'b1;
                    dq_count          = dq_count + 1'b1;
                end
            end
            default:
            begin
                if (dq_count == 0)
                    res.status = STAT_UNDERFLOW;
                else if (kind == REQ_POP_FRONT)
                begin
                    res.popped = dq_slots[dq_head];
                    dq_head    = dq_head + 1'b1;
                    dq_count   = dq_count - 1'b1;
                end
                else
                begin
                    dq_tail    = dq_tail - 1'b1;
                    res.popped = dq_slots[dq_tail];
                    dq_count   = dq_count - 1'b1;
                end
            end
        endcase

        // Front and rear words read as zero once the deque is empty.
        if (dq_count != 0)
        begin
            res.front = dq_slots[dq_head];
            res.rear  = dq_slots[dq_tail - 1'b1];
        end
        res.occupancy = dq_count;
        res.empty     = (dq_count == 0);
    endtask

    // Offer requests from the pending queue, holding each until its transfer.
    always @(negedge clk)
    begin : request_driver
        request_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken))
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = request_queue.pop_front();
                req_type   <= nxt.kind;
                push_value <= nxt.word;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver side: random stalls plus the long hold-off.
    always @(negedge clk)
    begin
        out_ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // The long hold-off is timed by its own process.
    initial
    begin
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Check result transfers first, then predict for a request transfer.
    always @(posedge clk)
    begin : result_monitor
        outcome_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    note_mismatch("result with nothing pending, popped_value",
                                  popped_value, '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (popped_value !== want.popped)
                        note_mismatch("popped_value", popped_value, want.popped);
                    if (status !== want.status)
                        note_mismatch("status", OUT_W'(status), OUT_W'(want.status));
                    if (occupancy !== want.occupancy)
                        note_mismatch("occupancy", OUT_W'(occupancy),
                                      OUT_W'(want.occupancy));
                    if (front_value !== want.front)
                        note_mismatch("front_value", front_value, want.front);
                    if (rear_value !== want.rear)
                        note_mismatch("rear_value", rear_value, want.rear);
                    if (is_empty !== want.empty)
                        note_mismatch("is_empty", OUT_W'(is_empty), OUT_W'(want.empty));
                end
            end
            if (in_valid && in_ready)
            begin
                apply_request(req_t'(req_type), push_value, want);
                awaited_results.push_back(want);
            end
        end
    end

    task automatic queue_request(input req_t kind, input logic [OUT_W-1:0] word);
        request_t r;
        r.kind = kind;
        r.word = word;
        request_queue.push_back(r);
    endtask

    // Random requests in runs that lean toward pushes, toward pops or neither, so that the
    // occupancy keeps swinging between empty and full and wraps the buffer.
    task automatic queue_random(input int count);
        int       left;
        int       run;
        int       push_bias;
        int       pick;
        req_t     kind;
        logic [OUT_W-1:0] word;
        left = count;
        while (left > 0)
        begin
            run = $urandom_range(48, 8);
            case ($urandom_range(2))
                0:       push_bias = 15;
                1:       push_bias = 50;
                default: push_bias = 85;
            endcase
            for (int i = 0; i < run && left > 0; i++)
            begin
                if ($urandom_range(99) < push_bias)
                    kind = ($urandom_range(1) != 0) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
                else
                    kind = ($urandom_range(1) != 0) ? REQ_POP_REAR : REQ_POP_FRONT;
                pick = $urandom_range(7);
                case (pick)
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7fff_ffff;
                    2:       word = OUT_W'($signed($urandom_range(32)) - 16);
                    default: word = $urandom;
                endcase
                queue_request(kind, word);
                left--;
            end
        end
    endtask

    // One phase: set the idling pattern, queue the requests, then pause the
    // sender until every expected result has come back.
    task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                             input bit with_hold);
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        queue_random(count);
        if (with_hold)
            hold_go = 1'b1;
        while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals on the empty queue, the extreme words at both ends, and
        // a pop from each end that empties the queue again.
        queue_request(REQ_POP_FRONT, 32'h0000_0000);
        queue_request(REQ_POP_REAR, 32'hffff_ffff);
        queue_request(REQ_PUSH_FRONT, 32'h8000_0000);
        queue_request(REQ_PUSH_REAR, 32'h7fff_ffff);
        queue_request(REQ_POP_FRONT, 32'h5555_5555);
        queue_request(REQ_POP_REAR, 32'haaaa_aaaa);
        queue_request(REQ_PUSH_REAR, 32'hffff_ffff);
        queue_request(REQ_PUSH_FRONT, 32'h0000_0000);

        // Fill to the limit from both ends, then refuse a push at each end.
        for (int i = 0; i < DEPTH - 2; i++)
            queue_request((i % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_REAR,
                          (32'h1 << (i * 2)) ^ {16{i[1:0]}});
        queue_request(REQ_PUSH_FRONT, 32'h1234_5678);
        queue_request(REQ_PUSH_REAR, 32'hdead_beef);

        run_phase(10, 80, 600, 1'b0);
        run_phase(80, 10, 600, 1'b0);
        run_phase(0, 0, 700, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            note_mismatch("results never delivered, count",
                          OUT_W'(awaited_results.size()), '0);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
